/* src/nbs_pkg.sv */
// Shared types and constants for the nested box suppression block.
// Depends on nothing; every other file but nbs_ram imports it.
package nbs_pkg;

  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 13;
  localparam int IDX_W       = 6;
  localparam int EDGE_W      = SIZE_W + 1;
  localparam int AREA_W      = 2 * SIZE_W;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } box_t;

  typedef struct packed {
    box_t              box;
    logic [AREA_W-1:0] area;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_STORE_LAST,
    CMD_DROP,
    CMD_DROP_LAST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    box_t      box;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ROW,
    B_ROWLD,
    B_COL,
    B_DRAIN,
    B_SCAN,
    B_EMIT,
    B_EMPTY,
    B_FINISH
  } back_state_t;

endpackage

/* src/nbs_box_if.sv */
// Input channel: one box request per handshake.
// Depends on nbs_pkg for field widths.
interface nbs_box_if import nbs_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] box_x;
  logic [COORD_W-1:0] box_y;
  logic [SIZE_W-1:0]  box_width;
  logic [SIZE_W-1:0]  box_height;
  logic               last_box;

  modport source(output valid, box_x, box_y, box_width, box_height, last_box, input ready);
  modport sink(input valid, box_x, box_y, box_width, box_height, last_box, output ready);
endinterface

/* src/nbs_kept_if.sv */
// Output channel: one surviving box, or the empty-set marker, per handshake.
// Depends on nbs_pkg for field widths.
interface nbs_kept_if import nbs_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] kept_x;
  logic [COORD_W-1:0] kept_y;
  logic [SIZE_W-1:0]  kept_width;
  logic [SIZE_W-1:0]  kept_height;
  logic [IDX_W-1:0]   kept_index;
  logic               last_kept;
  logic               none_kept;
  logic               overflow;

  modport source(output valid, kept_x, kept_y, kept_width, kept_height, kept_index,
                 last_kept, none_kept, overflow, input ready);
  modport sink(input valid, kept_x, kept_y, kept_width, kept_height, kept_index,
               last_kept, none_kept, overflow, output ready);
endinterface

/* src/nbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/nbs_front.sv */
// Front end: accepts box requests, tracks set fill and tags each as store or drop.
// Depends on nbs_pkg and nbs_box_if.
module nbs_front import nbs_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  logic       clk,
  input  logic       rst,
  nbs_box_if.sink    box_in,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             room;

  assign box_in.ready = !q_full;
  assign push         = box_in.valid && box_in.ready;
  assign room         = count < CNT_W'(MAX_BOXES);

  always_comb begin
    push_cmd.box.x = box_in.box_x;
    push_cmd.box.y = box_in.box_y;
    push_cmd.box.w = box_in.box_width;
    push_cmd.box.h = box_in.box_height;
    if (room) begin
      push_cmd.kind = box_in.last_box ? CMD_STORE_LAST : CMD_STORE;
    end else begin
      push_cmd.kind = box_in.last_box ? CMD_DROP_LAST : CMD_DROP;
    end
    count_next = count;
    if (push) begin
      if (box_in.last_box) begin
        count_next = '0;
      end else if (room) begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

/* src/nbs_queue.sv */
// Short request queue between front and back ends.
// Depends on nbs_pkg.
module nbs_queue import nbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slots [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QC_W-1:0] fill;
  logic            do_pop;

  assign full       = fill == QC_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QA_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QA_W'(1);
      end
      if (push && !do_pop) begin
        fill <= fill + QC_W'(1);
      end else if (do_pop && !push) begin
        fill <= fill - QC_W'(1);
      end
    end
  end

endmodule

/* src/nbs_back.sv */
// Back end: stores boxes, runs the pairwise containment pass, emits survivors.
// Depends on nbs_pkg, nbs_kept_if and nbs_ram.
module nbs_back import nbs_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_ready,
  nbs_kept_if.source kept_out
);

  localparam int AW    = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int ENT_W = $bits(entry_t);

  back_state_t          state, state_next;
  logic [CNT_W-1:0]     n, n_next;
  logic                 ovf, ovf_next;
  logic [AW-1:0]        i, i_next;
  logic [CNT_W-1:0]     j, j_next;
  logic [CNT_W-1:0]     k, k_next;
  logic                 any_kept, any_next;
  logic [MAX_BOXES-1:0] drop, drop_next;
  entry_t               bi;
  logic                 bi_load;

  logic                 wr_en;
  entry_t               wr_entry;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [ENT_W-1:0]     rd_data;
  entry_t               rd_entry;

  logic                 col_rd;
  logic [CNT_W-1:0]     col_idx;
  logic                 p0;
  logic [AW-1:0]        p0_idx;

  logic                 s1_valid, s1_empty;
  logic [SIZE_W-1:0]    s1_dx, s1_dy;
  logic [AREA_W-1:0]    s1_ai, s1_aj;
  logic [AW-1:0]        s1_ii, s1_jj;
  logic                 s2_valid;
  logic [AREA_W-1:0]    s2_ov, s2_ai, s2_aj;
  logic [AW-1:0]        s2_ii, s2_jj;

  logic [COORD_W-1:0]   x1, y1;
  logic [EDGE_W-1:0]    xa2, xb2, ya2, yb2, x2, y2;
  logic                 empty_a;

  logic                 store;
  logic [CNT_W-1:0]     n_new;
  logic                 out_free, out_load, out_none_load, later_any;

  logic                 out_valid;
  box_t                 out_box;
  logic [IDX_W-1:0]     out_index;
  logic                 out_last, out_none, out_ovf;

  nbs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(n[AW-1:0]),
    .wr_data(wr_entry),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_entry      = entry_t'(rd_data);
  assign wr_entry.box  = cmd.box;
  assign wr_entry.area = AREA_W'(cmd.box.w) * AREA_W'(cmd.box.h);

  // overlap geometry of box i against the column box just read
  always_comb begin
    x1  = (bi.box.x > rd_entry.box.x) ? bi.box.x : rd_entry.box.x;
    y1  = (bi.box.y > rd_entry.box.y) ? bi.box.y : rd_entry.box.y;
    xa2 = EDGE_W'(bi.box.x) + EDGE_W'(bi.box.w);
    xb2 = EDGE_W'(rd_entry.box.x) + EDGE_W'(rd_entry.box.w);
    ya2 = EDGE_W'(bi.box.y) + EDGE_W'(bi.box.h);
    yb2 = EDGE_W'(rd_entry.box.y) + EDGE_W'(rd_entry.box.h);
    x2  = (xa2 < xb2) ? xa2 : xb2;
    y2  = (ya2 < yb2) ? ya2 : yb2;
    empty_a = (EDGE_W'(x1) >= x2) || (EDGE_W'(y1) >= y2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0       <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      p0       <= col_rd;
      s1_valid <= p0;
      s2_valid <= s1_valid;
    end
    p0_idx   <= col_idx[AW-1:0];
    s1_empty <= empty_a;
    s1_dx    <= SIZE_W'(x2 - EDGE_W'(x1));
    s1_dy    <= SIZE_W'(y2 - EDGE_W'(y1));
    s1_ai    <= bi.area;
    s1_aj    <= rd_entry.area;
    s1_ii    <= i;
    s1_jj    <= p0_idx;
    s2_ov    <= s1_empty ? '0 : AREA_W'(s1_dx) * AREA_W'(s1_dy);
    s2_ai    <= s1_ai;
    s2_aj    <= s1_aj;
    s2_ii    <= s1_ii;
    s2_jj    <= s1_jj;
    if (bi_load) begin
      bi <= rd_entry;
    end
  end

  assign out_free = !out_valid || kept_out.ready;

  always_comb begin
    later_any = 1'b0;
    for (int m = 0; m < MAX_BOXES; m++) begin
      if (!drop[m] && CNT_W'(m) < n && CNT_W'(m) > k) begin
        later_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_next    = state;
    n_next        = n;
    ovf_next      = ovf;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    any_next      = any_kept;
    drop_next     = drop;
    bi_load       = 1'b0;
    col_rd        = 1'b0;
    col_idx       = j;
    rd_en         = 1'b0;
    rd_addr       = k[AW-1:0];
    wr_en         = 1'b0;
    cmd_ready     = 1'b0;
    out_load      = 1'b0;
    out_none_load = 1'b0;
    store         = (cmd.kind == CMD_STORE) || (cmd.kind == CMD_STORE_LAST);
    n_new         = n + CNT_W'(store);

    if (s2_valid) begin
      if (s2_ov == s2_ai) begin
        drop_next[s2_ii] = 1'b1;
      end else if (s2_ov == s2_aj) begin
        drop_next[s2_jj] = 1'b1;
      end
    end

    case (state)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          wr_en  = store;
          n_next = n_new;
          if (!store) begin
            ovf_next = 1'b1;
          end
          if (cmd.kind == CMD_STORE_LAST || cmd.kind == CMD_DROP_LAST) begin
            i_next     = '0;
            k_next     = '0;
            any_next   = 1'b0;
            state_next = (n_new >= CNT_W'(2)) ? B_ROW : B_SCAN;
          end
        end
      end
      B_ROW: begin
        rd_en      = 1'b1;
        rd_addr    = i;
        state_next = B_ROWLD;
      end
      B_ROWLD: begin
        bi_load    = 1'b1;
        col_idx    = CNT_W'(i) + CNT_W'(1);
        rd_en      = 1'b1;
        rd_addr    = col_idx[AW-1:0];
        col_rd     = 1'b1;
        j_next     = CNT_W'(i) + CNT_W'(2);
        state_next = B_COL;
      end
      B_COL: begin
        if (j < n) begin
          rd_en   = 1'b1;
          rd_addr = j[AW-1:0];
          col_rd  = 1'b1;
          j_next  = j + CNT_W'(1);
        end else if (CNT_W'(i) + CNT_W'(2) < n) begin
          i_next     = i + AW'(1);
          state_next = B_ROW;
        end else begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!p0 && !s1_valid && !s2_valid) begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (k == n) begin
          state_next = any_kept ? B_FINISH : B_EMPTY;
        end else if (drop[k[AW-1:0]]) begin
          k_next = k + CNT_W'(1);
        end else begin
          rd_en      = 1'b1;
          rd_addr    = k[AW-1:0];
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          any_next   = 1'b1;
          k_next     = k + CNT_W'(1);
          state_next = B_SCAN;
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          out_none_load = 1'b1;
          state_next    = B_FINISH;
        end
      end
      B_FINISH: begin
        drop_next  = '0;
        n_next     = '0;
        ovf_next   = 1'b0;
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      n        <= '0;
      ovf      <= 1'b0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      any_kept <= 1'b0;
      drop     <= '0;
    end else begin
      state    <= state_next;
      n        <= n_next;
      ovf      <= ovf_next;
      i        <= i_next;
      j        <= j_next;
      k        <= k_next;
      any_kept <= any_next;
      drop     <= drop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load || out_none_load) begin
      out_valid <= 1'b1;
    end else if (kept_out.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_box   <= rd_entry.box;
      out_index <= IDX_W'(k);
      out_last  <= !later_any;
      out_none  <= 1'b0;
      out_ovf   <= ovf;
    end else if (out_none_load) begin
      out_box   <= '0;
      out_index <= '0;
      out_last  <= 1'b1;
      out_none  <= 1'b1;
      out_ovf   <= ovf;
    end
  end

  assign kept_out.valid       = out_valid;
  assign kept_out.kept_x      = out_box.x;
  assign kept_out.kept_y      = out_box.y;
  assign kept_out.kept_width  = out_box.w;
  assign kept_out.kept_height = out_box.h;
  assign kept_out.kept_index  = out_index;
  assign kept_out.last_kept   = out_last;
  assign kept_out.none_kept   = out_none;
  assign kept_out.overflow    = out_ovf;

  a_marks_clear_idle: assert property (@(posedge clk) disable iff (rst)
    state == B_IDLE |-> drop == '0)
    else $error("drop marks not cleared between sets");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_store_has_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> n < CNT_W'(MAX_BOXES))
    else $error("store request with full box memory");

  a_pipe_in_pass: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == B_COL || state == B_ROW || state == B_ROWLD || state == B_DRAIN))
    else $error("compare pipeline active outside the pairwise pass");

endmodule

/* src/nested_box_suppression.sv */
// Top level of nested box suppression: front end, request queue, back end.
// Depends on nbs_pkg, nbs_box_if, nbs_kept_if, nbs_front, nbs_queue, nbs_back.
//
// Boxes enter one per cycle, while the four-entry queue is not full; a set closes at the
// box flagged last_box, and boxes past MAX_BOXES are dropped and reported through
// overflow. The back end then runs a pairwise containment pass over the n stored boxes
// through the single read port of the box memory, each row box against every later box.
// Survivors then leave in load order, each held until the output register is free; a set
// with no survivor yields one result with none_kept set. Boxes of the next set are queued
// while a set is processed.
module nested_box_suppression import nbs_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  logic       clk,
  input  logic       rst,
  nbs_box_if.sink    box_in,
  nbs_kept_if.source kept_out
);

  logic push, q_full, head_valid, pop;
  cmd_t push_cmd, head;

  nbs_front #(.MAX_BOXES(MAX_BOXES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .box_in  (box_in),
    .q_full  (q_full),
    .push    (push),
    .push_cmd(push_cmd)
  );

  nbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  nbs_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(head_valid),
    .cmd      (head),
    .cmd_ready(pop),
    .kept_out (kept_out)
  );

endmodule

/* test/tb_top.sv */
// Self-checking bench for nested_box_suppression: random box sets in, surviving boxes out.
// Depends on nbs_pkg, nbs_box_if, nbs_kept_if and the nested_box_suppression top level.
// A local containment predictor builds each set's survivors and checks every kept result.
module tb_top;
  import nbs_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int BOX_TOTAL = 180;

  typedef struct packed {
    box_t box;
    logic last_flag;
  } box_req_t;

  typedef struct packed {
    box_t             box;
    logic [IDX_W-1:0] idx;
    logic             last_flag;
    logic             none_flag;
    logic             ovf_flag;
  } kept_t;

  logic clk = 1'b0;
  logic rst;

  nbs_box_if  box_if();
  nbs_kept_if kept_if();

  nested_box_suppression #(.MAX_BOXES(NUM_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .box_in(box_if),
    .kept_out(kept_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  box_req_t box_reqs[$];
  kept_t    survivors_q[$];
  box_t     set_boxes[NUM_SLOTS];
  int       set_count = 0;
  logic     set_overflow = 1'b0;
  int       errors = 0;
  logic     calm = 1'b0;
  int       send_gap = 0;
  int       hold_cnt = 0;
  box_req_t next_req;
  kept_t    got;

  function automatic longint unsigned overlap_area(box_t a, box_t b);
    longint unsigned al, ar, at, ab, bl, br, bt, bb, x1, x2, y1, y2;
    al = 64'(a.x); ar = al + 64'(a.w); at = 64'(a.y); ab = at + 64'(a.h);
    bl = 64'(b.x); br = bl + 64'(b.w); bt = 64'(b.y); bb = bt + 64'(b.h);
    x1 = al > bl ? al : bl;
    x2 = ar < br ? ar : br;
    y1 = at > bt ? at : bt;
    y2 = ab < bb ? ab : bb;
    if (x1 >= x2 || y1 >= y2) return 0;
    return (x2 - x1) * (y2 - y1);
  endfunction

  task automatic suppress_set();
    bit              dropped[NUM_SLOTS];
    longint unsigned ai, aj, ov;
    int              last_i;
    kept_t           k;
    foreach (dropped[i]) dropped[i] = 1'b0;
    for (int i = 0; i < set_count; i++) begin
      ai = 64'(set_boxes[i].w) * 64'(set_boxes[i].h);
      for (int j = i + 1; j < set_count; j++) begin
        aj = 64'(set_boxes[j].w) * 64'(set_boxes[j].h);
        ov = overlap_area(set_boxes[i], set_boxes[j]);
        if (ov == ai) dropped[i] = 1'b1;
        else if (ov == aj) dropped[j] = 1'b1;
      end
    end
    last_i = -1;
    for (int i = 0; i < set_count; i++)
      if (!dropped[i]) last_i = i;
    if (last_i < 0) begin
      k = '0;
      k.last_flag = 1'b1;
      k.none_flag = 1'b1;
      k.ovf_flag  = set_overflow;
      survivors_q = {survivors_q, k};
    end else begin
      for (int i = 0; i < set_count; i++) begin
        if (!dropped[i]) begin
          k.box       = set_boxes[i];
          k.idx       = i[IDX_W-1:0];
          k.last_flag = (i == last_i);
          k.none_flag = 1'b0;
          k.ovf_flag  = set_overflow;
          survivors_q = {survivors_q, k};
        end
      end
    end
  endtask

  task automatic absorb_box(box_t b, logic last_flag);
    if (set_count < NUM_SLOTS) begin
      set_boxes[set_count] = b;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (last_flag) begin
      suppress_set();
      set_count    = 0;
      set_overflow = 1'b0;
    end
  endtask

  function automatic int clip(int v, int hi);
    return v < 0 ? 0 : (v > hi ? hi : v);
  endfunction

  function automatic box_t rand_box(box_t prev[$]);
    box_t b;
    int   kind, px, py, pw, ph, dx, dy;
    kind = prev.size() == 0 ? 0 : $urandom_range(0, 5);
    if (prev.size() != 0) begin
      b  = prev[$urandom_range(0, prev.size() - 1)];
      px = int'(b.x); py = int'(b.y); pw = int'(b.w); ph = int'(b.h);
    end
    case (kind)
      0, 1: begin
        if ($urandom_range(0, 3) == 0) begin
          b.x = COORD_W'($urandom_range(0, 4095));
          b.y = COORD_W'($urandom_range(0, 4095));
          b.w = SIZE_W'($urandom_range(0, 8191));
          b.h = SIZE_W'($urandom_range(0, 8191));
        end else begin
          b.x = COORD_W'($urandom_range(0, 63));
          b.y = COORD_W'($urandom_range(0, 63));
          b.w = SIZE_W'($urandom_range(0, 48));
          b.h = SIZE_W'($urandom_range(0, 48));
        end
      end
      2: ;
      3: begin
        dx  = $urandom_range(0, pw);
        dy  = $urandom_range(0, ph);
        b.x = COORD_W'(clip(px + dx, 4095));
        b.y = COORD_W'(clip(py + dy, 4095));
        b.w = SIZE_W'($urandom_range(0, pw - dx));
        b.h = SIZE_W'($urandom_range(0, ph - dy));
      end
      4: begin
        dx  = $urandom_range(0, px < 20 ? px : 20);
        dy  = $urandom_range(0, py < 20 ? py : 20);
        b.x = COORD_W'(px - dx);
        b.y = COORD_W'(py - dy);
        b.w = SIZE_W'(clip(pw + dx + int'($urandom_range(0, 20)), 8191));
        b.h = SIZE_W'(clip(ph + dy + int'($urandom_range(0, 20)), 8191));
      end
      default: begin
        b.x = COORD_W'(clip(px + int'($urandom_range(0, 10)) - 5, 4095));
        b.y = COORD_W'(clip(py + int'($urandom_range(0, 10)) - 5, 4095));
        b.w = SIZE_W'(clip(pw + int'($urandom_range(0, 6)) - 3, 8191));
        b.h = SIZE_W'(clip(ph + int'($urandom_range(0, 6)) - 3, 8191));
      end
    endcase
    return b;
  endfunction

  task automatic add_box(int x, int y, int w, int h, logic last_flag);
    box_req_t r;
    r.box.x     = COORD_W'(x);
    r.box.y     = COORD_W'(y);
    r.box.w     = SIZE_W'(w);
    r.box.h     = SIZE_W'(h);
    r.last_flag = last_flag;
    box_reqs    = {box_reqs, r};
  endtask

  task automatic add_set(int n);
    box_t     prev[$];
    box_req_t r;
    for (int i = 0; i < n; i++) begin
      r.box       = rand_box(prev);
      r.last_flag = (i == n - 1);
      prev        = {prev, r.box};
      box_reqs    = {box_reqs, r};
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      box_if.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      calm <= (box_reqs.size() < 40);
      if (!box_if.valid || box_if.ready) begin
        if (send_gap > 0 || box_reqs.size() == 0) begin
          box_if.valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          next_req = box_reqs.pop_front();
          box_if.box_x      <= next_req.box.x;
          box_if.box_y      <= next_req.box.y;
          box_if.box_width  <= next_req.box.w;
          box_if.box_height <= next_req.box.h;
          box_if.last_box   <= next_req.last_flag;
          box_if.valid      <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 19);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      kept_if.ready <= 1'b0;
      hold_cnt      <= 0;
    end else begin
      if (kept_if.valid && kept_if.ready) begin
        got.box.x     = kept_if.kept_x;
        got.box.y     = kept_if.kept_y;
        got.box.w     = kept_if.kept_width;
        got.box.h     = kept_if.kept_height;
        got.idx       = kept_if.kept_index;
        got.last_flag = kept_if.last_kept;
        got.none_flag = kept_if.none_kept;
        got.ovf_flag  = kept_if.overflow;
        if (survivors_q.size() == 0) begin
          errors++;
          $display("%0t unexpected kept box: x=%0d y=%0d w=%0d h=%0d idx=%0d",
                   $time, got.box.x, got.box.y, got.box.w, got.box.h, got.idx);
        end else if (got !== survivors_q[0]) begin
          errors++;
          $display({"%0t kept mismatch: expected x=%0d y=%0d w=%0d h=%0d idx=%0d",
                    " last=%0b none=%0b ovf=%0b"},
                   $time, survivors_q[0].box.x, survivors_q[0].box.y, survivors_q[0].box.w,
                   survivors_q[0].box.h, survivors_q[0].idx, survivors_q[0].last_flag,
                   survivors_q[0].none_flag, survivors_q[0].ovf_flag);
          $display("%0t   actual x=%0d y=%0d w=%0d h=%0d idx=%0d last=%0b none=%0b ovf=%0b",
                   $time, got.box.x, got.box.y, got.box.w, got.box.h, got.idx,
                   got.last_flag, got.none_flag, got.ovf_flag);
        end
        if (survivors_q.size() != 0) void'(survivors_q.pop_front());
      end
      if (box_if.valid && box_if.ready) begin
        absorb_box({box_if.box_x, box_if.box_y, box_if.box_width, box_if.box_height},
                   box_if.last_box);
      end
      if (hold_cnt > 0) begin
        hold_cnt      <= hold_cnt - 1;
        kept_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        hold_cnt      <= $urandom_range(1, 19) - 1;
        kept_if.ready <= 1'b0;
      end else begin
        kept_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    bit big_done;
    rst                = 1'b1;
    box_if.valid       = 1'b0;
    box_if.box_x       = '0;
    box_if.box_y       = '0;
    box_if.box_width   = '0;
    box_if.box_height  = '0;
    box_if.last_box    = 1'b0;
    kept_if.ready      = 1'b0;

    add_box(4095, 4095, 8191, 8191, 1);
    add_box(0, 0, 0, 0, 1);
    add_box(10, 10, 20, 20, 0);    add_box(10, 10, 20, 20, 1);
    add_box(0, 0, 100, 100, 0);    add_box(10, 10, 5, 5, 1);
    add_box(10, 10, 5, 5, 0);      add_box(0, 0, 100, 100, 1);
    add_box(0, 0, 10, 10, 0);      add_box(100, 100, 10, 10, 1);
    add_box(0, 0, 10, 10, 0);      add_box(10, 0, 10, 10, 1);
    add_box(0, 0, 10, 10, 0);      add_box(5, 5, 10, 10, 1);
    add_box(5, 5, 0, 0, 0);        add_box(5, 5, 0, 3, 0);      add_box(40, 40, 0, 7, 1);
    add_box(0, 0, 50, 50, 0);      add_box(20, 20, 0, 0, 1);
    add_box(4000, 0, 8191, 4096, 0);
    add_box(4095, 4095, 1, 1, 0);
    add_box(0, 4095, 4096, 8191, 1);
    add_box(2730, 1365, 5461, 2730, 1);

    big_done = 1'b0;
    while (box_reqs.size() < BOX_TOTAL) begin
      if (!big_done && box_reqs.size() > 60) begin
        add_set(NUM_SLOTS + 1 + $urandom_range(0, 1));
        big_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        add_set($urandom_range(10, 20));
      end else begin
        add_set($urandom_range(1, 8));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (box_reqs.size() != 0 || box_if.valid || survivors_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* nested_box_suppression.f */
src/nbs_pkg.sv
src/nbs_box_if.sv
src/nbs_kept_if.sv
src/nbs_ram.sv
src/nbs_front.sv
src/nbs_queue.sv
src/nbs_back.sv
src/nested_box_suppression.sv
test/tb_top.sv
